// ===== src/hed_pkg.sv =====
package hed_pkg;

   // message position counter width, and the width of the reported position
   localparam int INDEX_BITS = 16;
   localparam int POS_BITS   = 16;

   localparam logic [7:0] ESCAPE_RESET = 8'h3d;  // '='

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic                out_has_byte;
      logic [7:0]          out_byte;
      logic                out_done;
      logic                out_ok;
      logic [POS_BITS-1:0] out_error_pos;
   } rsp_type;

   typedef enum logic [2:0] {
      PH_PLAIN  = 3'b001,
      PH_DIGIT1 = 3'b010,
      PH_DIGIT2 = 3'b100
   } phase_type;

endpackage

// ===== src/hex_escape_decoder_unit.sv =====
// hex escape decoder
// decodes a byte stream in which an escape byte (csr_data, '=' after reset)
// is followed by two hex digits of either case; all other bytes pass as is
// input channel: one raw byte per beat on req_data, in_last marks the end of
// the message; a beat is taken when req_valid is high and req_stall is low
// result channel: at most one beat per input beat, carrying a decoded byte,
// the end-of-message report (ok, or the index of the failing escape), or both
// each result is registered: in the output register, or in the skid if that is held
// throughput: one input beat per cycle while req_stall is low; the decode is a
// single pass of combinational logic between the input handshake and the result register
// a two-entry result buffer (output register plus skid) lets the block keep
// taking beats while a result waits; req_stall rises only when both entries
// are full, and is driven straight from a flop
// while rsp_stall is high the result on rsp_* holds steady
// after an error the rest of the message is swallowed; the last beat still
// yields a failure report
// reset (synchronous, active high) empties the buffer, clears message state
// and loads '=' as escape byte; csr writes belong where no beat is in flight
module hex_escape_decoder_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hed_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hed_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [7:0]       csr_data
);
   import hed_pkg::*;

   localparam int WIDE_BITS = (INDEX_BITS > POS_BITS) ? INDEX_BITS : POS_BITS;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   // configuration
   logic [7:0] escape_ff;

   // message state
   phase_type             phase_ff, phase_in;
   logic [3:0]            high_nibble_ff, high_nibble_in;
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic [INDEX_BITS-1:0] escape_index_ff, escape_index_in;
   logic                  failed_ff, failed_in;
   logic                  first_zero_ff, first_zero_in;

   // result buffer
   logic    out_valid_ff, skid_valid_ff;
   rsp_type out_ff, skid_ff;

   logic          accept;
   logic          take;
   logic          produce;
   logic          is_hex;
   logic [3:0]    digit;
   logic          emit;
   logic [7:0]    value;
   rsp_type       result;
   logic [WIDE_BITS-1:0] esc_wide;
   logic [POS_BITS-1:0]  err_pos;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // hex digit lookup on the incoming byte
   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (req_data.in_byte inside {["0":"9"]}) begin
         digit = 4'(req_data.in_byte - 8'h30);
      end else if (req_data.in_byte inside {["a":"f"]}) begin
         digit = 4'(req_data.in_byte - 8'h57);
      end else if (req_data.in_byte inside {["A":"F"]}) begin
         digit = 4'(req_data.in_byte - 8'h37);
      end else begin
         is_hex = 1'b0;
      end
   end

   // per-byte decode step
   always_comb begin
      phase_in        = phase_ff;
      high_nibble_in  = high_nibble_ff;
      escape_index_in = escape_index_ff;
      failed_in       = failed_ff;
      first_zero_in   = first_zero_ff;
      emit            = 1'b0;
      value           = 8'd0;
      byte_index_in   = (byte_index_ff != '1) ? byte_index_ff + 1'b1 : byte_index_ff;

      if (!failed_ff) begin
         case (phase_ff)
            PH_PLAIN: begin
               if (req_data.in_byte == escape_ff) begin
                  escape_index_in = byte_index_ff;
                  if (req_data.in_last) failed_in = 1'b1;
                  else                  phase_in  = PH_DIGIT1;
               end else begin
                  emit  = 1'b1;
                  value = req_data.in_byte;
               end
            end
            PH_DIGIT1: begin
               if (!is_hex || req_data.in_last) begin
                  failed_in = 1'b1;
               end else begin
                  high_nibble_in = digit;
                  first_zero_in  = (req_data.in_byte == "0");
                  phase_in       = PH_DIGIT2;
               end
            end
            PH_DIGIT2: begin
               // "00" is rejected
               if (!is_hex || (first_zero_ff && req_data.in_byte == "0")) begin
                  failed_in = 1'b1;
               end else begin
                  emit  = 1'b1;
                  value = {high_nibble_ff, digit};
               end
               phase_in = PH_PLAIN;
            end
            default: begin
               phase_in = PH_PLAIN;
            end
         endcase
      end

      // reported position saturates at its field width
      esc_wide = WIDE_BITS'(escape_index_in);
      if (esc_wide > WIDE_BITS'(POS_MAX)) err_pos = POS_MAX;
      else                                 err_pos = esc_wide[POS_BITS-1:0];

      produce              = emit | req_data.in_last;
      result.out_has_byte  = emit;
      result.out_byte      = value;
      result.out_done      = req_data.in_last;
      result.out_ok        = req_data.in_last & ~failed_in;
      result.out_error_pos = (req_data.in_last && failed_in) ? err_pos : '0;

      // end of message returns all message state to its reset value
      if (req_data.in_last) begin
         phase_in        = PH_PLAIN;
         high_nibble_in  = 4'd0;
         byte_index_in   = '0;
         escape_index_in = '0;
         failed_in       = 1'b0;
         first_zero_in   = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff       <= ESCAPE_RESET;
         phase_ff        <= PH_PLAIN;
         high_nibble_ff  <= 4'd0;
         byte_index_ff   <= '0;
         escape_index_ff <= '0;
         failed_ff       <= 1'b0;
         first_zero_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            escape_ff <= csr_data;
         end
         if (accept) begin
            phase_ff        <= phase_in;
            high_nibble_ff  <= high_nibble_in;
            byte_index_ff   <= byte_index_in;
            escape_index_ff <= escape_index_in;
            failed_ff       <= failed_in;
            first_zero_ff   <= first_zero_in;
         end
         if (!out_valid_ff || take) begin
            // output register free this cycle: skid drains first
            if (skid_valid_ff) begin
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= accept & produce;
            end
         end else if (accept && produce) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (accept)   out_ff <= result;
      end else if (accept && produce) begin
         skid_ff <= result;
      end
   end

endmodule
